[hw/rtl/ikhm_pkg.sv]
// Package for the integer-key hash map core.
// Holds the word types of the request, response and slot memory, plus the
// table sizes, hash constants and action codes. Depends on nothing.
`timescale 1ns / 1ps

package ikhm_pkg;

   // Table geometry: the slot count is a power of two.
   localparam int SLOT_BITS  = 10;
   localparam int SLOTS      = 1 << SLOT_BITS;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 10;
   localparam int LIMIT_BITS = 10;

   localparam logic [SLOT_BITS-1:0]  SLOT_LAST     = SLOT_BITS'(SLOTS - 1);
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET   = LIMIT_BITS'(767);

   // Key mix multipliers.
   localparam logic [KEY_BITS-1:0] MIX_MUL_A = 32'h7feb352d;
   localparam logic [KEY_BITS-1:0] MIX_MUL_B = 32'h846ca68b;

   // Action codes; any other code behaves as a lookup.
   localparam logic [1:0] ACT_PUT    = 2'd0;
   localparam logic [1:0] ACT_GET    = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   // Response status codes.
   localparam logic STAT_DONE = 1'b0;
   localparam logic STAT_FULL = 1'b1;

   typedef struct packed {
      logic [1:0]                 action;
      logic signed [KEY_BITS-1:0] key;
      logic [VALUE_BITS-1:0]      value;
   } req_word_type;

   typedef struct packed {
      logic                  found;
      logic [VALUE_BITS-1:0] value_out;
      logic                  status;
      logic [COUNT_BITS-1:0] entry_count;
   } rsp_word_type;

   typedef struct packed {
      logic                  used;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] val;
   } slot_word_type;

endpackage

[hw/rtl/int_key_hash_map_core.sv]
// Integer-key hash map core: open addressing with linear probing in a slot memory.
// Uses ikhm_pkg for word types, sizes, hash constants and action codes.
// The response word is registered: after acceptance come two mix rounds on one shared
// multiplier, a fold to the home slot, the probes, and the post once the output is free.
// A remove then lifts out, rehashes and re-probes each later member up to the cluster end.
// Throughput: one word at a time; ready again in the cycle the response word turns valid.
// Reset (synchronous): a clearing pass over the table marks every slot empty; no
// request is taken meanwhile, configuration writes are taken at any time.
`timescale 1ns / 1ps

module int_key_hash_map_core
   import ikhm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   // Response channel.
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   // Configuration register: entry limit.
   input  logic                  csr_we,
   input  logic [LIMIT_BITS-1:0] csr_wdata
);

   // Sequencer states.
   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_HASH1   = 4'd2;
   localparam logic [3:0] ST_HASH2   = 4'd3;
   localparam logic [3:0] ST_HASH3   = 4'd4;
   localparam logic [3:0] ST_PROBE   = 4'd5;
   localparam logic [3:0] ST_REM_RD  = 4'd6;
   localparam logic [3:0] ST_REM_CHK = 4'd7;
   localparam logic [3:0] ST_FIN     = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [KEY_BITS-1:0]   mix_ff, mix_in;
   logic [SLOT_BITS-1:0]  idx_ff, idx_in;
   logic [SLOT_BITS-1:0]  hop_ff, hop_in;
   logic                  move_ff, move_in;
   logic                  found_ff, found_in;
   logic [VALUE_BITS-1:0] vout_ff, vout_in;
   logic                  stat_ff, stat_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [LIMIT_BITS-1:0] max_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_data_ff, rsp_data_in;

   // Slot memory: one write port, one registered read port.
   slot_word_type         slot_mem [SLOTS];
   slot_word_type         rd_ff;
   logic [SLOT_BITS-1:0]  mem_raddr;
   logic                  mem_we;
   logic [SLOT_BITS-1:0]  mem_waddr;
   slot_word_type         mem_wdata;

   // Shared multiplier for both mix rounds.
   logic [KEY_BITS-1:0]   mul_a, mul_b, mul_lo;
   logic [KEY_BITS-1:0]   key_fold, mix_fold1, mix_fold2;

   // Probe compare results on the slot just read.
   logic                  slot_empty, key_hit, room_left;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign key_fold  = key_ff ^ (key_ff >> 16);
   assign mix_fold1 = mix_ff ^ (mix_ff >> 15);
   assign mix_fold2 = mix_ff ^ (mix_ff >> 16);

   // The first round multiplies the folded key, the second the folded product.
   assign mul_a  = (state_ff == ST_HASH1) ? key_fold : mix_fold1;
   assign mul_b  = (state_ff == ST_HASH1) ? MIX_MUL_A : MIX_MUL_B;
   assign mul_lo = mul_a * mul_b;

   assign slot_empty = !rd_ff.used;
   assign key_hit    = rd_ff.used && (rd_ff.key == key_ff) && !move_ff;
   assign room_left  = (LIMIT_BITS'(count_ff) < max_ff) && (count_ff != COUNT_BITS'(SLOTS - 1));

   // Sequencer next-state and datapath logic.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      mix_in       = mix_ff;
      idx_in       = idx_ff;
      hop_in       = hop_ff;
      move_in      = move_ff;
      found_in     = found_ff;
      vout_in      = vout_ff;
      stat_in      = stat_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_raddr    = idx_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = '{used: 1'b1, key: key_ff, val: val_ff};

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep the table once, marking each slot empty.
            mem_we         = 1'b1;
            mem_wdata.used = 1'b0;
            idx_in         = idx_ff + 1'b1;
            if (idx_ff == SLOT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.action;
               key_in   = req_data.key;
               val_in   = req_data.value;
               move_in  = 1'b0;
               found_in = 1'b0;
               vout_in  = '0;
               stat_in  = STAT_DONE;
               state_in = ST_HASH1;
            end
         end
         ST_HASH1: begin
            mix_in   = mul_lo;
            state_in = ST_HASH2;
         end
         ST_HASH2: begin
            mix_in   = mul_lo;
            state_in = ST_HASH3;
         end
         ST_HASH3: begin
            // Home slot: fetch it so that its word is ready in the probe state.
            idx_in    = mix_fold2[SLOT_BITS-1:0];
            mem_raddr = mix_fold2[SLOT_BITS-1:0];
            state_in  = ST_PROBE;
         end
         ST_PROBE: begin
            if (move_ff) begin
               // Re-placing a cluster member: drop it into the first empty slot.
               if (slot_empty) begin
                  mem_we   = 1'b1;
                  hop_in   = hop_ff + 1'b1;
                  state_in = ST_REM_RD;
               end else begin
                  idx_in    = idx_ff + 1'b1;
                  mem_raddr = idx_ff + 1'b1;
               end
            end else if (slot_empty || key_hit) begin
               found_in = key_hit;
               state_in = ST_FIN;
               unique case (op_ff)
                  ACT_PUT: begin
                     if (key_hit) begin
                        mem_we = 1'b1;
                     end else if (room_left) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        stat_in = STAT_FULL;
                     end
                  end
                  ACT_REMOVE: begin
                     if (key_hit) begin
                        vout_in        = rd_ff.val;
                        mem_we         = 1'b1;
                        mem_wdata      = rd_ff;
                        mem_wdata.used = 1'b0;
                        count_in       = count_ff - 1'b1;
                        hop_in         = idx_ff + 1'b1;
                        state_in       = ST_REM_RD;
                     end
                  end
                  default: begin
                     vout_in = key_hit ? rd_ff.val : '0;
                  end
               endcase
            end else begin
               idx_in    = idx_ff + 1'b1;
               mem_raddr = idx_ff + 1'b1;
            end
         end
         ST_REM_RD: begin
            mem_raddr = hop_ff;
            state_in  = ST_REM_CHK;
         end
         ST_REM_CHK: begin
            // End of the cluster, or lift this member out and rehash its key.
            if (slot_empty) begin
               state_in = ST_FIN;
            end else begin
               key_in         = rd_ff.key;
               val_in         = rd_ff.val;
               move_in        = 1'b1;
               mem_we         = 1'b1;
               mem_waddr      = hop_ff;
               mem_wdata      = rd_ff;
               mem_wdata.used = 1'b0;
               state_in       = ST_HASH1;
            end
         end
         ST_FIN: begin
            // Post the response word once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.found       = found_ff;
               rsp_data_in.value_out   = vout_ff;
               rsp_data_in.status      = stat_ff;
               rsp_data_in.entry_count = count_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         move_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         move_ff      <= move_in;
      end
   end

   // Entry limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         max_ff <= csr_wdata;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      mix_ff      <= mix_in;
      hop_ff      <= hop_in;
      found_ff    <= found_in;
      vout_ff     <= vout_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Slot memory write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= slot_mem[mem_raddr];
   end

   // An accepted request always starts the key mix.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_HASH1))
      else $error("accepted request did not start hashing");

   // The stored count moves by at most one per cycle.
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((count_ff == $past(count_ff)) ||
                (count_ff == $past(count_ff) + 1'b1) ||
                (count_ff == $past(count_ff) - 1'b1)))
      else $error("stored count jumped");

   // A refused put never reports the key as present.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.status && rsp_data.found))
      else $error("full status together with found");

   // Re-placing a cluster member only ever writes an occupied slot.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE && move_ff && mem_we) |-> mem_wdata.used)
      else $error("re-placed entry written as empty");

endmodule
